// ===== src/lsdc_pkg.sv =====
// ============================================================================
// lsdc_pkg: shared types and constants for the LED session duty controller
// Holds the command codes, event codes, register indexes, the configuration
// record and the word formats that pass between the pipeline stages.
// ============================================================================
`default_nettype none

package lsdc_pkg;

    localparam int unsigned LEVEL_W  = 12;
    localparam int unsigned TIME_W   = 16;
    localparam int unsigned MS_W     = 10;
    localparam int unsigned PHASE_W  = TIME_W + 1;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned EVENT_W  = 3;

    localparam logic [MS_W-1:0]   MS_PER_SECOND = 10'd1000;
    localparam logic [MS_W-1:0]   BLINK_HALF_MS = 10'd500;
    localparam logic [TIME_W-1:0] SECONDS_MAX   = 16'hFFFF;

    localparam logic [LEVEL_W-1:0] RST_LED_LEVEL  = 12'd2048;
    localparam logic [TIME_W-1:0]  RST_ON_TIME    = 16'd10000;
    localparam logic [TIME_W-1:0]  RST_OFF_TIME   = 16'd5000;
    localparam logic [TIME_W-1:0]  RST_SESSION_S  = 16'd1200;
    // 15757 raw counts of 0.02 K is 42.0 degrees Celsius.
    localparam logic [TIME_W-1:0]  RST_TEMP_LIMIT = 16'd15757;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_TEMP  = 2'd3
    } t_mode;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_STARTED  = 3'd1,
        EV_STOPPED  = 3'd2,
        EV_COMPLETE = 3'd3,
        EV_THERMAL  = 3'd4
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_LEVEL  = 3'd0,
        CFG_ON_TIME    = 3'd1,
        CFG_OFF_TIME   = 3'd2,
        CFG_SESSION_S  = 3'd3,
        CFG_TEMP_LIMIT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] led_level;
        logic [TIME_W-1:0]  on_time_ms;
        logic [TIME_W-1:0]  off_time_ms;
        logic [TIME_W-1:0]  session_seconds;
        logic [TIME_W-1:0]  temp_limit_raw;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic [TIME_W-1:0]  temp_raw;
        logic               temp_ok;
    } t_in_word;

    typedef struct packed {
        logic               leds_lit;
        logic [LEVEL_W-1:0] drive_level;
        logic               session_running;
        logic [TIME_W-1:0]  elapsed_seconds;
        logic               status_blink;
        t_event             event_res;
    } t_result;

endpackage

`default_nettype wire

// ===== src/lsdc_cfg_regs.sv =====
// ============================================================================
// lsdc_cfg_regs: configuration register file
// Five write-only registers loaded from the plain write port.
// ============================================================================
`default_nettype none

module lsdc_cfg_regs
    import lsdc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TIME_W-1:0]    i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_level       <= RST_LED_LEVEL;
            r_cfg.on_time_ms      <= RST_ON_TIME;
            r_cfg.off_time_ms     <= RST_OFF_TIME;
            r_cfg.session_seconds <= RST_SESSION_S;
            r_cfg.temp_limit_raw  <= RST_TEMP_LIMIT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LED_LEVEL:  r_cfg.led_level       <= i_cfg_data[LEVEL_W-1:0];
                CFG_ON_TIME:    r_cfg.on_time_ms      <= i_cfg_data;
                CFG_OFF_TIME:   r_cfg.off_time_ms     <= i_cfg_data;
                CFG_SESSION_S:  r_cfg.session_seconds <= i_cfg_data;
                CFG_TEMP_LIMIT: r_cfg.temp_limit_raw  <= i_cfg_data;
                default: begin
                    // Indexes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/lsdc_in_stage.sv =====
// ============================================================================
// lsdc_in_stage: input register and input-side handshake
// Captures one word per cycle while o_stall is low and hands it to the
// session core as soon as the result register can take the outcome.
// ============================================================================
`default_nettype none

module lsdc_in_stage
    import lsdc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_mode,
    input  wire logic [TIME_W-1:0] i_temp_raw,
    input  wire logic              i_temp_ok,
    input  wire logic              i_out_hold,
    output logic                   o_adv,
    output t_in_word               o_word
);

    logic     r_valid;
    logic     n_valid;
    t_in_word r_word;
    logic     accept;

    // The held word moves on whenever the result register is not blocked.
    assign o_adv   = r_valid && !i_out_hold;
    assign o_stall = r_valid && i_out_hold;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.mode     <= t_mode'(i_mode);
            r_word.temp_raw <= i_temp_raw;
            r_word.temp_ok  <= i_temp_ok;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== src/lsdc_core.sv =====
// ============================================================================
// lsdc_core: session state and single-pass update logic
// Holds the session counters and computes the next state and the result
// word for the word presented by the input register.
// ============================================================================
`default_nettype none

module lsdc_core
    import lsdc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    logic               r_session_on, n_session_on;
    logic               r_leds_on,    n_leds_on;
    logic [MS_W-1:0]    r_ms,         n_ms;
    logic [TIME_W-1:0]  r_sec,        n_sec;
    logic [PHASE_W-1:0] r_phase,      n_phase;
    logic [MS_W-1:0]    r_blink,      n_blink;

    logic [PHASE_W-1:0] cycle_len;
    logic [PHASE_W-1:0] phase_inc;
    logic [MS_W-1:0]    ms_inc;
    logic [MS_W-1:0]    blink_inc;
    logic [TIME_W-1:0]  sec_sat;
    t_event             event_code;

    assign cycle_len = {1'b0, i_cfg.on_time_ms} + {1'b0, i_cfg.off_time_ms};
    assign phase_inc = r_phase + PHASE_W'(1);
    assign ms_inc    = r_ms + MS_W'(1);
    assign blink_inc = r_blink + MS_W'(1);
    assign sec_sat   = (r_sec == SECONDS_MAX) ? r_sec : r_sec + TIME_W'(1);

    always_comb begin
        n_session_on = r_session_on;
        n_leds_on    = r_leds_on;
        n_ms         = r_ms;
        n_sec        = r_sec;
        n_phase      = r_phase;
        n_blink      = r_blink;
        event_code   = EV_NONE;
        case (i_word.mode)
            MODE_TICK: begin
                n_blink = (blink_inc >= MS_PER_SECOND) ? '0 : blink_inc;
                if (r_session_on) begin
                    if (ms_inc >= MS_PER_SECOND) begin
                        n_ms  = '0;
                        n_sec = sec_sat;
                    end else begin
                        n_ms  = ms_inc;
                    end
                    if (n_sec >= i_cfg.session_seconds) begin
                        n_session_on = 1'b0;
                        n_leds_on    = 1'b0;
                        event_code   = EV_COMPLETE;
                    end else if (cycle_len == '0) begin
                        n_phase   = '0;
                        n_leds_on = 1'b0;
                    end else begin
                        n_phase   = (phase_inc >= cycle_len) ? '0 : phase_inc;
                        n_leds_on = (n_phase < {1'b0, i_cfg.on_time_ms});
                    end
                end else begin
                    n_leds_on = 1'b0;
                end
            end
            MODE_START: begin
                n_session_on = 1'b1;
                n_ms         = '0;
                n_sec        = '0;
                n_phase      = '0;
                n_leds_on    = (i_cfg.on_time_ms != '0) && (i_cfg.session_seconds != '0);
                event_code   = EV_STARTED;
            end
            MODE_STOP: begin
                if (r_session_on) begin
                    event_code = EV_STOPPED;
                end
                n_session_on = 1'b0;
                n_leds_on    = 1'b0;
            end
            MODE_TEMP: begin
                if (r_session_on && i_word.temp_ok
                        && (i_word.temp_raw > i_cfg.temp_limit_raw)) begin
                    n_session_on = 1'b0;
                    n_leds_on    = 1'b0;
                    event_code   = EV_THERMAL;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.leds_lit        = n_leds_on;
        o_result.drive_level     = n_leds_on ? i_cfg.led_level : '0;
        o_result.session_running = n_session_on;
        o_result.elapsed_seconds = n_sec;
        o_result.status_blink    = n_session_on && (n_blink >= BLINK_HALF_MS);
        o_result.event_res       = event_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_on <= 1'b0;
            r_leds_on    <= 1'b0;
            r_ms         <= '0;
            r_sec        <= '0;
            r_phase      <= '0;
            r_blink      <= '0;
        end else if (i_adv) begin
            r_session_on <= n_session_on;
            r_leds_on    <= n_leds_on;
            r_ms         <= n_ms;
            r_sec        <= n_sec;
            r_phase      <= n_phase;
            r_blink      <= n_blink;
        end
    end

endmodule

`default_nettype wire

// ===== src/lsdc_out_stage.sv =====
// ============================================================================
// lsdc_out_stage: result register and output-side handshake
// Holds one result word until the consumer takes it.
// ============================================================================
`default_nettype none

module lsdc_out_stage
    import lsdc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  t_result   i_result,
    input  wire logic i_stall,
    output logic      o_valid,
    output logic      o_hold,
    output t_result   o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_hold = r_valid && i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== src/led_session_duty_controller.sv =====
// ============================================================================
// led_session_duty_controller: session timer for a pulsed LED array
// Times a treatment session, runs the on/off duty cycle of the LEDs, stops
// on completion, on command or on a skin temperature over the limit.
// ============================================================================
//
//   Channel   Direction  Handshake            Word
//   --------  ---------  -------------------  ---------------------------------
//   input     in         i_valid / o_stall    mode, temp_raw, temp_ok
//   result    out        o_valid / i_stall    leds_lit, drive_level, running,
//                                             elapsed_seconds, blink, event
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data (16 bit)
//
// Every input word yields exactly one result word. When the output is not
// stalled, the word passes from the input register to the result register,
// from which the consumer can take it.
// A new word is accepted in every cycle while o_stall is low; the rate is
// set by the single update pass of the session core, which sits between
// the input register and the result register.
// Reset is synchronous and active low; it restores the register defaults
// and clears the session state. A stall on the result side holds the result
// register; when the input register is full as well, it holds too and
// o_stall rises in that same cycle, so one word waits in each register.
//
// Input words carry one of four commands. A tick advances the blink counter
// always and, while a session runs, the millisecond, second and duty-phase
// counters; the session completes once the elapsed seconds reach the set
// length. Start clears the counters and (re)opens the session. Stop closes
// it. A good temperature sample above the limit closes a running session.
// The LEDs are lit while the duty phase is below the on time; a zero-length
// duty cycle keeps them dark. The result reflects the state after the word.
// ============================================================================
`default_nettype none

module led_session_duty_controller
    import lsdc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_mode,
    input  wire logic [TIME_W-1:0]    i_temp_raw,
    input  wire logic                 i_temp_ok,

    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_leds_lit,
    output logic [LEVEL_W-1:0]        o_drive_level,
    output logic                      o_session_running,
    output logic [TIME_W-1:0]         o_elapsed_seconds,
    output logic                      o_status_blink,
    output logic [EVENT_W-1:0]        o_event_res,

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [TIME_W-1:0]    i_cfg_data
);

    t_cfg     cfg;
    t_in_word in_word;
    t_result  core_result;
    t_result  out_result;
    logic     adv;
    logic     out_hold;

    // The user must write configuration only while no word is in flight; the block itself does not enforce it.
    lsdc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lsdc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_temp_raw (i_temp_raw),
        .i_temp_ok  (i_temp_ok),
        .i_out_hold (out_hold),
        .o_adv      (adv),
        .o_word     (in_word)
    );

    // The session state commits in the same edge that loads the result.
    lsdc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_word   (in_word),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    lsdc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_hold   (out_hold),
        .o_result (out_result)
    );

    assign o_leds_lit        = out_result.leds_lit;
    assign o_drive_level     = out_result.drive_level;
    assign o_session_running = out_result.session_running;
    assign o_elapsed_seconds = out_result.elapsed_seconds;
    assign o_status_blink    = out_result.status_blink;
    assign o_event_res       = out_result.event_res;

endmodule

`default_nettype wire

// ===== src/lsdc_checker.sv =====
// ============================================================================
// lsdc_port_props: port-level checks for the LED session duty controller
// Watches the result channel for handshake and consistency slips.
// ============================================================================
`default_nettype none

module lsdc_port_props
    import lsdc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic               o_leds_lit,
    input wire logic [LEVEL_W-1:0] o_drive_level,
    input wire logic               o_session_running,
    input wire logic [TIME_W-1:0]  o_elapsed_seconds,
    input wire logic               o_status_blink,
    input wire logic [EVENT_W-1:0] o_event_res
);

    // A stalled result word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_res)
            && $stable(o_elapsed_seconds) && $stable(o_drive_level))
        else $error("result word changed while stalled");

    a_dark_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_session_running |-> !o_leds_lit && !o_status_blink)
        else $error("LEDs or blink active without a session");

    a_dark_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_leds_lit |-> o_drive_level == '0)
        else $error("drive level nonzero while LEDs are dark");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_event_res == EV_STARTED |->
            o_session_running && o_elapsed_seconds == '0)
        else $error("start word does not show a fresh session");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_STOPPED || o_event_res == EV_COMPLETE
            || o_event_res == EV_THERMAL) |-> !o_session_running)
        else $error("session still running after an end event");

endmodule

bind led_session_duty_controller lsdc_port_props u_lsdc_port_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_leds_lit        (o_leds_lit),
    .o_drive_level     (o_drive_level),
    .o_session_running (o_session_running),
    .o_elapsed_seconds (o_elapsed_seconds),
    .o_status_blink    (o_status_blink),
    .o_event_res       (o_event_res)
);

`default_nettype wire

// ===== verif/lsdc_checker.sv =====
// ============================================================================
// lsdc_checker: result predictor and comparator for the LED session timer
// Watches the input, result and register ports of the block. It keeps its
// own copy of the session state to predict each result word, then compares
// every accepted result word, field by field, with the oldest prediction.
// ============================================================================

module lsdc_checker
    import lsdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [1:0]           i_mode,
    input  logic [TIME_W-1:0]    i_temp_raw,
    input  logic                 i_temp_ok,

    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic                 i_leds_lit,
    input  logic [LEVEL_W-1:0]   i_drive_level,
    input  logic                 i_session_running,
    input  logic [TIME_W-1:0]    i_elapsed_seconds,
    input  logic                 i_status_blink,
    input  logic [EVENT_W-1:0]   i_event_res,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_data,

    output int                   o_mismatches,
    output int                   o_pending
);

    t_cfg               regs;
    logic               session_on;
    logic               leds_on;
    logic [MS_W-1:0]    ms_in_sec;
    logic [MS_W-1:0]    blink_ms;
    logic [TIME_W-1:0]  secs;
    logic [PHASE_W-1:0] phase;

    t_result expected_status_q[$];
    int      mismatch_count = 0;
    int      waiting = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = waiting;

    // Applies one input word to the session state and returns the status word.
    function automatic t_result advance_session(input t_in_word w);
        t_event         ev;
        logic [17:0]    cycle_len;
        t_result        r;
        ev = EV_NONE;
        cycle_len = {2'b00, regs.on_time_ms} + {2'b00, regs.off_time_ms};
        case (w.mode)
            MODE_TICK: begin
                blink_ms = (blink_ms + 10'd1 >= MS_PER_SECOND) ? '0 : blink_ms + 10'd1;
                if (session_on) begin
                    ms_in_sec = ms_in_sec + 10'd1;
                    if (ms_in_sec >= MS_PER_SECOND) begin
                        ms_in_sec = '0;
                        if (secs != SECONDS_MAX)
                            secs = secs + 16'd1;
                    end
                    if (secs >= regs.session_seconds) begin
                        session_on = 1'b0;
                        leds_on    = 1'b0;
                        ev         = EV_COMPLETE;
                    end else if (cycle_len == 18'd0) begin
                        phase   = '0;
                        leds_on = 1'b0;
                    end else begin
                        phase   = ({1'b0, phase} + 18'd1 >= cycle_len) ? '0 : phase + 17'd1;
                        leds_on = phase < {1'b0, regs.on_time_ms};
                    end
                end else begin
                    leds_on = 1'b0;
                end
            end
            MODE_START: begin
                session_on = 1'b1;
                ms_in_sec  = '0;
                secs       = '0;
                phase      = '0;
                leds_on    = (regs.on_time_ms != '0) && (regs.session_seconds != '0);
                ev         = EV_STARTED;
            end
            MODE_STOP: begin
                if (session_on)
                    ev = EV_STOPPED;
                session_on = 1'b0;
                leds_on    = 1'b0;
            end
            default: begin
                if (session_on && w.temp_ok && w.temp_raw > regs.temp_limit_raw) begin
                    session_on = 1'b0;
                    leds_on    = 1'b0;
                    ev         = EV_THERMAL;
                end
            end
        endcase
        r.leds_lit        = leds_on;
        r.drive_level     = leds_on ? regs.led_level : '0;
        r.session_running = session_on;
        r.elapsed_seconds = secs;
        r.status_blink    = session_on && (blink_ms >= BLINK_HALF_MS);
        r.event_res       = ev;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_in_word word;
        t_result  want;
        if (!i_rst_n) begin
            regs       = {RST_LED_LEVEL, RST_ON_TIME, RST_OFF_TIME, RST_SESSION_S,
                          RST_TEMP_LIMIT};
            session_on = 1'b0;
            leds_on    = 1'b0;
            ms_in_sec  = '0;
            blink_ms   = '0;
            secs       = '0;
            phase      = '0;
            expected_status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LED_LEVEL:  regs.led_level       = i_cfg_data[LEVEL_W-1:0];
                    CFG_ON_TIME:    regs.on_time_ms      = i_cfg_data;
                    CFG_OFF_TIME:   regs.off_time_ms     = i_cfg_data;
                    CFG_SESSION_S:  regs.session_seconds = i_cfg_data;
                    CFG_TEMP_LIMIT: regs.temp_limit_raw  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                word.mode     = t_mode'(i_mode);
                word.temp_raw = i_temp_raw;
                word.temp_ok  = i_temp_ok;
                expected_status_q.push_back(advance_session(word));
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_status_q.size() == 0) begin
                    $error("result word accepted with no prediction waiting");
                    mismatch_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("leds_lit", want.leds_lit, i_leds_lit);
                    check_field("drive_level", want.drive_level, i_drive_level);
                    check_field("session_running", want.session_running, i_session_running);
                    check_field("elapsed_seconds", want.elapsed_seconds, i_elapsed_seconds);
                    check_field("status_blink", want.status_blink, i_status_blink);
                    check_field("event_res", want.event_res, i_event_res);
                end
            end
        end
        waiting = expected_status_q.size();
    end

endmodule

// ===== verif/tb_led_session_duty_controller.sv =====
// ============================================================================
// tb_led_session_duty_controller: top of the LED session timer testbench
// Drives input words and register writes into the block, stalls the result
// side in random bursts, and reports the verdict. Prediction and comparison
// live in lsdc_checker, which sits beside the block and counts mismatches.
// ============================================================================

module tb_led_session_duty_controller;
    import lsdc_pkg::*;

    // Roughly 800 words, even with idle and stall bursts in the worst case,
    // fit well below this bound.
    localparam int CYCLE_LIMIT = 600000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_mode;
    logic [TIME_W-1:0]    i_temp_raw;
    logic                 i_temp_ok;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_leds_lit;
    logic [LEVEL_W-1:0]   o_drive_level;
    logic                 o_session_running;
    logic [TIME_W-1:0]    o_elapsed_seconds;
    logic                 o_status_blink;
    logic [EVENT_W-1:0]   o_event_res;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [TIME_W-1:0]    i_cfg_data;

    int   mismatches;
    int   pending;
    int   cycle_count;
    // When set, both the sender and the receiver insert random idle bursts.
    logic idling;
    // Mirror of the register settings, used to aim temperatures at the limit.
    t_cfg cur_cfg;

    led_session_duty_controller u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_temp_raw        (i_temp_raw),
        .i_temp_ok         (i_temp_ok),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_leds_lit        (o_leds_lit),
        .o_drive_level     (o_drive_level),
        .o_session_running (o_session_running),
        .o_elapsed_seconds (o_elapsed_seconds),
        .o_status_blink    (o_status_blink),
        .o_event_res       (o_event_res),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    lsdc_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_mode            (i_mode),
        .i_temp_raw        (i_temp_raw),
        .i_temp_ok         (i_temp_ok),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_leds_lit        (o_leds_lit),
        .i_drive_level     (o_drive_level),
        .i_session_running (o_session_running),
        .i_elapsed_seconds (o_elapsed_seconds),
        .i_status_blink    (o_status_blink),
        .i_event_res       (o_event_res),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result-side back pressure. A burst holds the stall high; between bursts
    // the stall is low. With idling off it stays low.
    initial begin : result_stall
        int burst;
        i_stall = 1'b0;
        burst   = 0;
        forever begin
            @(posedge i_clk);
            if (!idling) begin
                burst   = 0;
                i_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                burst   = $urandom_range(1, 14) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Offers one word and returns at the edge where it is accepted. The
    // valid stays high on return so back-to-back words need no gap.
    task automatic send_word(input t_mode m, input logic [TIME_W-1:0] raw, input logic ok);
        int gap;
        if (idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= m;
        i_temp_raw <= raw;
        i_temp_ok  <= ok;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stops offering words and waits until every predicted result word has
    // come back. The count is sampled on the falling edge, away from the
    // checker's updates, and the task returns on a rising edge.
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // One register write; the caller drops the write enable afterwards.
    task automatic put_reg(input t_cfg_idx idx, input logic [TIME_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Writes all five registers. The unused top bits of the level write carry
    // random values, which the block must ignore.
    task automatic load_regs(input t_cfg c);
        drain();
        cur_cfg = c;
        put_reg(CFG_LED_LEVEL, {4'($urandom), c.led_level});
        put_reg(CFG_ON_TIME, c.on_time_ms);
        put_reg(CFG_OFF_TIME, c.off_time_ms);
        put_reg(CFG_SESSION_S, c.session_seconds);
        put_reg(CFG_TEMP_LIMIT, c.temp_limit_raw);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.led_level       = 12'($urandom);
        c.on_time_ms      = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 40));
        c.off_time_ms     = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 40));
        c.session_seconds = 16'($urandom_range(0, 3));
        c.temp_limit_raw  = 16'($urandom);
        return c;
    endfunction

    // Unstructured mix of all four commands. Half of the temperatures land
    // within two counts of the limit so that the strict comparison is hit
    // from both sides; fields a command ignores still carry random values.
    task automatic run_random(input int n);
        int                roll;
        t_mode             m;
        logic [TIME_W-1:0] raw;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
                m = MODE_TICK;
            else if (roll < 73)
                m = MODE_START;
            else if (roll < 80)
                m = MODE_STOP;
            else
                m = MODE_TEMP;
            if ($urandom_range(0, 1) == 0)
                raw = cur_cfg.temp_limit_raw + 16'($urandom_range(0, 4)) - 16'd2;
            else
                raw = 16'($urandom);
            send_word(m, raw, $urandom_range(0, 4) != 0);
        end
    endtask

    // A well-formed session: an optional start, then a run of ticks with an
    // occasional temperature sample that cannot trip (failed read or at or
    // below the limit), so the counters get far enough to wrap the duty
    // phase and run the blink.
    task automatic run_session(input logic with_start, input int ticks);
        if (with_start)
            send_word(MODE_START, 16'($urandom), $urandom_range(0, 1));
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(0, 29) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    send_word(MODE_TEMP, 16'($urandom), 1'b0);
                else
                    send_word(MODE_TEMP, 16'($urandom_range(0, cur_cfg.temp_limit_raw)), 1'b1);
            end else begin
                send_word(MODE_TICK, 16'($urandom), $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        t_cfg c;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_mode     = MODE_TICK;
        i_temp_raw = '0;
        i_temp_ok  = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_LED_LEVEL;
        i_cfg_data = '0;
        idling     = 1'b0;
        cur_cfg    = {RST_LED_LEVEL, RST_ON_TIME, RST_OFF_TIME, RST_SESSION_S, RST_TEMP_LIMIT};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset settings: commands while idle, restart,
        // the temperature limit exactly, one above it, and a failed read.
        send_word(MODE_STOP, 16'h0000, 1'b0);
        send_word(MODE_TEMP, 16'hFFFF, 1'b1);
        send_word(MODE_TICK, 16'h0000, 1'b0);
        send_word(MODE_START, 16'h0000, 1'b0);
        send_word(MODE_TICK, 16'hFFFF, 1'b1);
        send_word(MODE_TICK, 16'h0000, 1'b0);
        send_word(MODE_TEMP, RST_TEMP_LIMIT, 1'b1);
        send_word(MODE_TEMP, 16'hFFFF, 1'b0);
        send_word(MODE_START, 16'hFFFF, 1'b1);
        send_word(MODE_TICK, 16'h0000, 1'b0);
        send_word(MODE_STOP, 16'h0000, 1'b0);
        send_word(MODE_STOP, 16'hFFFF, 1'b1);
        send_word(MODE_START, 16'h0000, 1'b0);
        send_word(MODE_TEMP, RST_TEMP_LIMIT + 16'd1, 1'b1);
        send_word(MODE_TEMP, 16'h0000, 1'b1);

        // Zero session length: the start leaves the LEDs dark and the first
        // tick completes the session. A limit of all ones can never trip.
        load_regs({12'hFFF, 16'd3, 16'd2, 16'd0, 16'hFFFF});
        send_word(MODE_START, 16'h0000, 1'b0);
        send_word(MODE_TICK, 16'h0000, 1'b0);
        send_word(MODE_START, 16'h0000, 1'b0);
        send_word(MODE_TEMP, 16'hFFFF, 1'b1);
        send_word(MODE_TICK, 16'h0000, 1'b0);

        // Zero duty cycle keeps the LEDs dark; a limit of zero trips on one.
        load_regs({12'h001, 16'd0, 16'd0, 16'd3, 16'd0});
        send_word(MODE_START, 16'h0000, 1'b0);
        send_word(MODE_TICK, 16'h0000, 1'b0);
        send_word(MODE_TEMP, 16'h0000, 1'b1);
        send_word(MODE_TEMP, 16'h0001, 1'b1);

        // Largest durations and duty times with the lowest level.
        idling <= 1'b1;
        load_regs({12'h000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0});
        run_random(60);

        // Sessions of one second on a short duty cycle: the duty phase wraps
        // many times over and the blink runs.
        c = random_cfg();
        c.on_time_ms      = 16'd3;
        c.off_time_ms     = 16'd4;
        c.session_seconds = 16'd1;
        load_regs(c);
        run_session(1'b1, 150);
        idling <= 1'b0;
        run_session(1'b1, 100);

        // Duty change while a session runs: the phase is far past the new
        // cycle length and must wrap on the next tick. Then the cycle drops
        // to zero mid-session.
        idling <= 1'b1;
        c = random_cfg();
        c.on_time_ms      = 16'd300;
        c.off_time_ms     = 16'd200;
        c.session_seconds = 16'd5;
        load_regs(c);
        run_session(1'b1, 120);
        drain();
        cur_cfg.on_time_ms  = 16'd20;
        cur_cfg.off_time_ms = 16'd10;
        put_reg(CFG_ON_TIME, 16'd20);
        put_reg(CFG_OFF_TIME, 16'd10);
        i_cfg_we <= 1'b0;
        run_session(1'b0, 40);
        drain();
        cur_cfg.on_time_ms  = 16'd0;
        cur_cfg.off_time_ms = 16'd0;
        put_reg(CFG_ON_TIME, 16'd0);
        put_reg(CFG_OFF_TIME, 16'd0);
        i_cfg_we <= 1'b0;
        run_session(1'b0, 10);

        // Random settings; every third phase runs without idle bursts.
        for (int p = 0; p < 6; p++) begin
            idling <= (p % 3 != 2);
            load_regs(random_cfg());
            run_random(45);
        end

        // Closing stretch at full rate on both sides.
        idling <= 1'b0;
        run_random(40);
        drain();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/lsdc_pkg.sv
src/lsdc_cfg_regs.sv
src/lsdc_in_stage.sv
src/lsdc_core.sv
src/lsdc_out_stage.sv
src/led_session_duty_controller.sv
src/lsdc_checker.sv
verif/lsdc_checker.sv
verif/tb_led_session_duty_controller.sv
